// ===== rtl/modexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg: shared types and constants
// Widths, controller states and the command/status structs that link the
// modular exponentiation controller and datapath.
// ----------------------------------------------------------------------------
package modexp_pkg;

   localparam int VALUE_WIDTH = 62;
   localparam int BASE_WIDTH  = 62;
   localparam int EXP_WIDTH   = 63;
   localparam int MOD_WIDTH   = 63;
   // working registers hold values below 2^(VALUE_WIDTH+1)
   localparam int WORK_WIDTH  = VALUE_WIDTH + 2;
   localparam int BIT_WIDTH   = $clog2(WORK_WIDTH);
   // bit count used by the reduction of the base
   localparam int RED_BITS    = BASE_WIDTH;
   localparam int RED_CNT_W   = $clog2(RED_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL_ACC,
      ST_MUL_SQR,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_REDUCE_STEP,
      OP_MUL_STEP
   } op_type;

   typedef struct packed {
      op_type op;
      logic   sel_sqr;   // multiply target: 1 = base*base, 0 = acc*base
      logic   mul_init;  // clear product and restart bit counter
      logic   mul_wb;    // write product back to its target
      logic   exp_shift; // drop lowest exponent bit
   } cmd_type;

   typedef struct packed {
      logic reduce_last;
      logic mul_last;
      logic exp_zero;
      logic exp_lsb;
   } status_type;

endpackage

// ===== rtl/modexp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_datapath: operand registers and bit-serial modular multiplier
// Holds base, exponent, modulus and accumulator. A restoring shift-subtract
// step reduces the base; a double-and-add step forms exact modular products.
// ----------------------------------------------------------------------------
module modexp_datapath (
   input  logic                                  clock,
   input  modexp_pkg::cmd_type                   cmd,
   input  logic [modexp_pkg::BASE_WIDTH-1:0]     req_base_value,
   input  logic [modexp_pkg::EXP_WIDTH-1:0]      req_exponent,
   input  logic [modexp_pkg::MOD_WIDTH-1:0]      req_modulus,
   output modexp_pkg::status_type                status,
   output logic [modexp_pkg::VALUE_WIDTH-1:0]    result
);

   localparam int W = modexp_pkg::WORK_WIDTH;

   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] mod_ff, mod_in;
   logic [W-1:0] prod_ff, prod_in;
   logic [modexp_pkg::EXP_WIDTH-1:0] exp_ff, exp_in;
   logic [modexp_pkg::BIT_WIDTH-1:0] bit_ff, bit_in;
   logic [modexp_pkg::RED_CNT_W-1:0] red_ff, red_in;
   logic [modexp_pkg::BASE_WIDTH-1:0] rsrc_ff, rsrc_in;

   logic [W-1:0] mod_sat;
   logic [W-1:0] dbl, dbl_r, add_v, add_r, mult_b, rem_sh, rem_r;
   logic         mbit;

   // modulus clamp: above 2^VALUE_WIDTH saturates, zero behaves like one
   always_comb begin
      if (req_modulus > modexp_pkg::MOD_WIDTH'(W'(1) << modexp_pkg::VALUE_WIDTH))
         mod_sat = W'(1) << modexp_pkg::VALUE_WIDTH;
      else if (req_modulus == '0)
         mod_sat = W'(1);
      else
         mod_sat = W'(req_modulus);
   end

   // one double-and-add step over the current multiplier bit
   always_comb begin
      mult_b = base_ff;
      mbit   = mult_b[bit_ff];
      dbl    = {prod_ff[W-2:0], 1'b0};
      dbl_r  = (dbl >= mod_ff) ? dbl - mod_ff : dbl;
      add_v  = dbl_r + (cmd.sel_sqr ? base_ff : acc_ff);
      add_r  = (add_v >= mod_ff) ? add_v - mod_ff : add_v;
   end

   // one restoring step of base reduction, msb first
   always_comb begin
      rem_sh = {base_ff[W-2:0], rsrc_ff[modexp_pkg::BASE_WIDTH-1]};
      rem_r  = (rem_sh >= mod_ff) ? rem_sh - mod_ff : rem_sh;
   end

   // register updates per command
   always_comb begin
      base_in = base_ff;
      acc_in  = acc_ff;
      mod_in  = mod_ff;
      prod_in = prod_ff;
      exp_in  = exp_ff;
      bit_in  = bit_ff;
      red_in  = red_ff;
      rsrc_in = rsrc_ff;
      unique case (cmd.op)
         modexp_pkg::OP_LOAD: begin
            mod_in  = mod_sat;
            exp_in  = req_exponent;
            rsrc_in = req_base_value;
            base_in = '0;
            acc_in  = (mod_sat == W'(1)) ? '0 : W'(1);
            red_in  = modexp_pkg::RED_CNT_W'(modexp_pkg::RED_BITS - 1);
         end
         modexp_pkg::OP_REDUCE_STEP: begin
            base_in = rem_r;
            rsrc_in = {rsrc_ff[modexp_pkg::BASE_WIDTH-2:0], 1'b0};
            red_in  = red_ff - 1'b1;
         end
         modexp_pkg::OP_MUL_STEP: begin
            prod_in = mbit ? add_r : dbl_r;
            bit_in  = bit_ff - 1'b1;
         end
         default: ;
      endcase
      if (cmd.mul_init) begin
         prod_in = '0;
         bit_in  = modexp_pkg::BIT_WIDTH'(W - 1);
      end
      if (cmd.mul_wb) begin
         if (cmd.sel_sqr) base_in = prod_ff;
         else             acc_in  = prod_ff;
      end
      if (cmd.exp_shift)
         exp_in = exp_ff >> 1;
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      acc_ff  <= acc_in;
      mod_ff  <= mod_in;
      prod_ff <= prod_in;
      exp_ff  <= exp_in;
      bit_ff  <= bit_in;
      red_ff  <= red_in;
      rsrc_ff <= rsrc_in;
   end

   // status back to the controller
   assign status.reduce_last = (red_ff == '0);
   assign status.mul_last    = (bit_ff == '0);
   assign status.exp_zero    = (exp_ff == '0);
   assign status.exp_lsb     = exp_ff[0];
   assign result             = acc_ff[modexp_pkg::VALUE_WIDTH-1:0];

endmodule

// ===== rtl/modexp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_ctrl: sequencing state machine
// Loads a beat, reduces the base, walks exponent bits issuing multiply
// passes, and holds the result register until the response beat is taken.
// ----------------------------------------------------------------------------
module modexp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  modexp_pkg::status_type status,
   output modexp_pkg::cmd_type    cmd
);

   modexp_pkg::state_type state_ff, state_in;
   logic                  busy_mul_ff, busy_mul_in; // multiply pass finished, write-back pending

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= modexp_pkg::ST_IDLE;
         busy_mul_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         busy_mul_ff <= busy_mul_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      busy_mul_in = busy_mul_ff;
      cmd         = '{op: modexp_pkg::OP_NONE, sel_sqr: 1'b0, mul_init: 1'b0,
                      mul_wb: 1'b0, exp_shift: 1'b0};
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         modexp_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = modexp_pkg::OP_LOAD;
               state_in = modexp_pkg::ST_REDUCE;
            end
         end
         modexp_pkg::ST_REDUCE: begin
            cmd.op = modexp_pkg::OP_REDUCE_STEP;
            if (status.reduce_last) state_in = modexp_pkg::ST_CHECK;
         end
         modexp_pkg::ST_CHECK: begin
            cmd.mul_init = 1'b1;
            if (status.exp_zero)     state_in = modexp_pkg::ST_DONE;
            else if (status.exp_lsb) state_in = modexp_pkg::ST_MUL_ACC;
            else                     state_in = modexp_pkg::ST_MUL_SQR;
         end
         modexp_pkg::ST_MUL_ACC: begin
            if (busy_mul_ff) begin
               // pass finished last cycle: write back, start squaring
               cmd.mul_wb   = 1'b1;
               cmd.mul_init = 1'b1;
               busy_mul_in  = 1'b0;
               state_in     = modexp_pkg::ST_MUL_SQR;
            end else begin
               cmd.op = modexp_pkg::OP_MUL_STEP;
               if (status.mul_last) busy_mul_in = 1'b1;
            end
         end
         modexp_pkg::ST_MUL_SQR: begin
            cmd.sel_sqr = 1'b1;
            if (busy_mul_ff) begin
               cmd.mul_wb    = 1'b1;
               cmd.exp_shift = 1'b1;
               busy_mul_in   = 1'b0;
               state_in      = modexp_pkg::ST_CHECK;
            end else begin
               cmd.op = modexp_pkg::OP_MUL_STEP;
               if (status.mul_last) busy_mul_in = 1'b1;
            end
         end
         modexp_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = modexp_pkg::ST_IDLE;
         end
         default: state_in = modexp_pkg::ST_IDLE;
      endcase
   end

   // response only from the done state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == modexp_pkg::ST_DONE)
      else $error("rsp_valid outside done state");
   // no new request taken while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("request accepted while response pending");
   // a held response stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

// ===== rtl/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation: base^exponent mod modulus
// Top level joining the sequencing controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
// One item at a time. An item is loaded, its base is reduced bit by bit,
// then for each exponent bit up to the highest set one the check state
// starts a multiply pass when the bit is set and then a square pass, all on
// one bit-serial double-and-add modular multiplier; a final visit to the
// check state then leads to the done state, which presents the result.
// The modulus saturates to 2^62 and a modulus of zero or one gives 0.
module modular_exponentiation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [modexp_pkg::BASE_WIDTH-1:0]   req_base_value,
   input  logic [modexp_pkg::EXP_WIDTH-1:0]    req_exponent,
   input  logic [modexp_pkg::MOD_WIDTH-1:0]    req_modulus,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [modexp_pkg::VALUE_WIDTH-1:0]  rsp_power_result
);

   modexp_pkg::cmd_type    cmd;
   modexp_pkg::status_type status;

   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   modexp_datapath u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .req_base_value (req_base_value),
      .req_exponent   (req_exponent),
      .req_modulus    (req_modulus),
      .status         (status),
      .result         (rsp_power_result)
   );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: modular exponentiation testbench
// Walks a table of directed cases, then random items, through the block with
// random idle gaps on both sides and one long result hold-off. Result beats
// are checked against typed table values or an in-file square-and-multiply model.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int ITEM_COUNT = 100;
   localparam logic [63:0] MOD_CAP = 64'd1 << modexp_pkg::VALUE_WIDTH;

   typedef struct {
      logic [modexp_pkg::BASE_WIDTH-1:0]  base_value;
      logic [modexp_pkg::EXP_WIDTH-1:0]   exponent;
      logic [modexp_pkg::MOD_WIDTH-1:0]   modulus;
      logic                               known;    // expected result typed into the table
      logic [modexp_pkg::VALUE_WIDTH-1:0] result;
   } case_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [modexp_pkg::BASE_WIDTH-1:0]  req_base_value = '0;
   logic [modexp_pkg::EXP_WIDTH-1:0]   req_exponent = '0;
   logic [modexp_pkg::MOD_WIDTH-1:0]   req_modulus = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b1;
   logic [modexp_pkg::VALUE_WIDTH-1:0] rsp_power_result;

   logic [modexp_pkg::VALUE_WIDTH-1:0] pending_powers[$];
   int mismatches = 0;
   bit sending_done = 0;
   bit hold_now = 0;
   case_type cases[$];

   modular_exponentiation DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // exact (a * b) mod m by double and add
   function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [63:0] acc;
      acc = 0;
      for (int i = 63; i >= 0; i--) begin
         acc = acc << 1;
         if (acc >= m) acc -= m;
         if (b[i]) begin
            acc += a;
            if (acc >= m) acc -= m;
         end
      end
      return acc;
   endfunction

   function automatic logic [modexp_pkg::VALUE_WIDTH-1:0] modpow(
         logic [modexp_pkg::BASE_WIDTH-1:0] b,
         logic [modexp_pkg::EXP_WIDTH-1:0] e, logic [modexp_pkg::MOD_WIDTH-1:0] md);
      logic [63:0] m, x, acc, ex;
      m = md;
      if (m > MOD_CAP) m = MOD_CAP;
      if (m <= 1) return '0;
      x = b % m;
      acc = 1;
      ex = e;
      while (ex != 0) begin
         if (ex[0]) acc = mulmod(acc, x, m);
         x = mulmod(x, x, m);
         ex = ex >> 1;
      end
      return acc[modexp_pkg::VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic add_case(logic [63:0] b, logic [63:0] e, logic [63:0] m,
         bit known, logic [63:0] r);
      case_type c;
      c.base_value = b[modexp_pkg::BASE_WIDTH-1:0];
      c.exponent = e[modexp_pkg::EXP_WIDTH-1:0];
      c.modulus = m[modexp_pkg::MOD_WIDTH-1:0];
      c.known = known;
      c.result = r[modexp_pkg::VALUE_WIDTH-1:0];
      cases = {cases, c};
   endtask

   // offer one beat and wait for it to be taken
   task automatic send_item(case_type c);
      int gap;
      logic [modexp_pkg::VALUE_WIDTH-1:0] want;
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_base_value <= c.base_value;
      req_exponent <= c.exponent;
      req_modulus <= c.modulus;
      want = c.known ? c.result : modpow(c.base_value, c.exponent, c.modulus);
      pending_powers = {pending_powers, want};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stimulus
   initial begin
      logic [63:0] b, e, m;
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed table: extremes and special cases
      add_case(0, 0, 1, 1, 0);                       // modulus one
      add_case(5, 3, 0, 1, 0);                       // modulus zero
      add_case(12345, 0, 7, 1, 1);                   // exponent zero
      add_case(64'h3FFF_FFFF_FFFF_FFFF, 0, MOD_CAP, 1, 1);
      add_case(0, 5, 13, 1, 0);                      // zero base
      add_case(2, 10, 64'd1000000, 1, 1024);
      add_case(3, 4, 100, 1, 81);
      add_case(2, 61, MOD_CAP, 1, 64'd1 << 61);
      add_case(2, 62, MOD_CAP, 1, 0);
      add_case(64'h3FFF_FFFF_FFFF_FFFF, 1, MOD_CAP, 1, 64'h3FFF_FFFF_FFFF_FFFF);
      add_case(7, 1, 64'h7FFF_FFFF_FFFF_FFFF, 1, 7); // modulus above range
      add_case(64'h3FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
               64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
      add_case(64'h3FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, MOD_CAP - 1, 0, 0);
      add_case(64'h2AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h1555_5555_5555_5557, 0, 0);
      add_case(64'h1555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA, 64'h2AAA_AAAA_AAAA_AAAB, 0, 0);
      add_case(10, 64'h7FFF_FFFF_FFFF_FFFE, 2, 1, 0);
      add_case(999, 64'd1 << 62, 64'd1000000007, 0, 0);
      // random part: mostly short exponents, some full width
      while (cases.size() < ITEM_COUNT) begin
         b = rand64();
         e = rand64();
         m = rand64();
         pick = $urandom_range(0, 9);
         if (pick < 5) e = e & 64'hFF;
         else if (pick < 7) e = e & 64'hFFFF_FFFF;
         if ($urandom_range(0, 9) == 0) m = $urandom_range(0, 3);
         else if ($urandom_range(0, 4) == 0) m = m & 64'hFFFF;
         add_case(b, e, m, 0, 0);
      end
      foreach (cases[i]) begin
         // long receiver hold-off partway through
         if (i == 20) hold_now = 1;
         send_item(cases[i]);
      end
      req_valid <= 1'b0;
      sending_done = 1;
   end

   // result side stall pattern
   initial begin
      int gap;
      @(negedge reset);
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_now) begin
            hold_now = 0;
            rsp_stall <= 1'b1;
            repeat (30000) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // result checking
   always @(posedge clock) begin
      logic [modexp_pkg::VALUE_WIDTH-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_powers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat %h", rsp_power_result);
         end else begin
            want = pending_powers.pop_front();
            if (rsp_power_result !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("power_result mismatch: expected %h actual %h",
                           want, rsp_power_result);
            end
         end
      end
   end

   // end of run
   initial begin
      wait (sending_done);
      while (pending_powers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending_powers.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // timeout: 100 items at worst case with gaps, plus the hold-off, about seven times over
   initial begin
      #50_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
